// File: design/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// Depends on nothing; every other design file refers to it by scoped names.
package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int AXI_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [AXI_BITS-1:0]   axial_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  localparam coord_t COORD_ONE = coord_t'(1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_POINT     = 3'd0,
    MODE_VERT      = 3'd1,
    MODE_HORIZ     = 3'd2,
    MODE_DIAG_UP   = 3'd3,
    MODE_SHALLOW   = 3'd4,
    MODE_STEEP     = 3'd5,
    MODE_DIAG_DOWN = 3'd6
  } walk_mode_t;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // Walk set-up derived from one pair of endpoints.
  typedef struct packed {
    walk_mode_t mode;
    coord_t     cur_x;
    coord_t     cur_y;
    coord_t     major_end;
    dec_t       dec;
    axial_t     axial;
    dec_t       diag;
    logic       minor_dir;
  } setup_t;

endpackage

// File: design/line_rasterizer_core.sv
// Line rasterizer top level: input register, line set-up and pixel walk.
// Depends on lr_pkg, lr_setup and lr_walk.
// A step transaction passes through in_r and in_valid_r, then its pixel through
// out_item_r and out_valid_r; out_valid is then high for exactly one cycle.
// Throughput: one transaction per cycle, loads and steps alike, while busy is low;
// the walk state registers are updated at most once per transaction.
// Reset: synchronous, active low; busy is high during reset and in the cycle after
// it, then stays low. No line is active after reset.
module line_rasterizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lr_pkg::in_item_t  in_item,
  output logic              out_valid,
  output lr_pkg::out_item_t out_item
);

  logic             busy_r;
  logic             accept;
  logic             in_valid_r;
  lr_pkg::in_item_t in_r;
  lr_pkg::setup_t   setup;

  // accept one transaction per cycle once out of reset
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // hold busy through reset, release it on the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= accept;
    end
  end

  // capture the transaction payload; drop it when nothing is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
  end

  // classify the latched endpoints and derive the walk increments
  lr_setup u_setup (
    .item  (in_r),
    .setup (setup)
  );

  // advance the walk and register one pixel per step on an active line
  lr_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_r),
    .setup      (setup),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r && in_r.command == lr_pkg::CMD_STEP))
    else $error("pixel without a step transaction");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && in_r.command == lr_pkg::CMD_LOAD |=> !out_valid)
    else $error("load transaction produced a pixel");

endmodule

// File: design/lr_setup.sv
// Line set-up: classifies a line and derives its walk start, end and increments.
// Depends on lr_pkg.
module lr_setup (
  input  lr_pkg::in_item_t item,
  output lr_pkg::setup_t   setup
);

  lr_pkg::delta_t dx;
  lr_pkg::delta_t dy;
  lr_pkg::mag_t   ax;
  lr_pkg::mag_t   ay;
  lr_pkg::mag_t   maj;
  lr_pkg::mag_t   mnr;
  logic           shallow;
  logic           swap;

  always_comb begin
    dx = lr_pkg::delta_t'(item.end_x) - lr_pkg::delta_t'(item.start_x);
    dy = lr_pkg::delta_t'(item.end_y) - lr_pkg::delta_t'(item.start_y);
    ax = dx[lr_pkg::DELTA_BITS-1] ? lr_pkg::mag_t'(-dx) : lr_pkg::mag_t'(dx);
    ay = dy[lr_pkg::DELTA_BITS-1] ? lr_pkg::mag_t'(-dy) : lr_pkg::mag_t'(dy);
    shallow = (ay < ax);
    maj = shallow ? ax : ay;
    mnr = shallow ? ay : ax;
    // walk shallow lines from the left end, steep lines from the low end
    swap = shallow ? dx[lr_pkg::DELTA_BITS-1] : dy[lr_pkg::DELTA_BITS-1];

    setup.dec   = lr_pkg::dec_t'({mnr, 1'b0}) - lr_pkg::dec_t'(maj);
    setup.axial = lr_pkg::axial_t'({mnr, 1'b0});
    setup.diag  = lr_pkg::dec_t'({mnr, 1'b0}) - lr_pkg::dec_t'({maj, 1'b0});
    setup.cur_x = item.start_x;
    setup.cur_y = item.start_y;
    setup.major_end = item.start_x;
    setup.minor_dir = 1'b0;

    if (dx == '0 && dy == '0) begin
      setup.mode = lr_pkg::MODE_POINT;
    end else if (dx == '0) begin
      setup.mode      = lr_pkg::MODE_VERT;
      setup.cur_y     = dy[lr_pkg::DELTA_BITS-1] ? item.end_y : item.start_y;
      setup.major_end = dy[lr_pkg::DELTA_BITS-1] ? item.start_y : item.end_y;
    end else if (dy == '0) begin
      setup.mode      = lr_pkg::MODE_HORIZ;
      setup.cur_x     = dx[lr_pkg::DELTA_BITS-1] ? item.end_x : item.start_x;
      setup.major_end = dx[lr_pkg::DELTA_BITS-1] ? item.start_x : item.end_x;
    end else if (ax == ay) begin
      setup.mode      = dx[lr_pkg::DELTA_BITS-1] ? lr_pkg::MODE_DIAG_DOWN
                                                 : lr_pkg::MODE_DIAG_UP;
      setup.minor_dir = dy[lr_pkg::DELTA_BITS-1];
      setup.major_end = item.end_x;
    end else if (shallow) begin
      setup.mode      = lr_pkg::MODE_SHALLOW;
      setup.cur_x     = swap ? item.end_x : item.start_x;
      setup.cur_y     = swap ? item.end_y : item.start_y;
      setup.major_end = swap ? item.start_x : item.end_x;
      setup.minor_dir = swap ? ~dy[lr_pkg::DELTA_BITS-1] : dy[lr_pkg::DELTA_BITS-1];
    end else begin
      setup.mode      = lr_pkg::MODE_STEEP;
      setup.cur_x     = swap ? item.end_x : item.start_x;
      setup.cur_y     = swap ? item.end_y : item.start_y;
      setup.major_end = swap ? item.start_y : item.end_y;
      setup.minor_dir = swap ? ~dx[lr_pkg::DELTA_BITS-1] : dx[lr_pkg::DELTA_BITS-1];
    end
  end

endmodule

// File: design/lr_walk.sv
// Line walk state: latches a set-up on load, steps one pixel per step command on
// an active line and registers the result. Depends on lr_pkg.
module lr_walk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  lr_pkg::in_item_t  item,
  input  lr_pkg::setup_t    setup,
  output logic              out_valid,
  output lr_pkg::out_item_t out_item
);

  logic               active_r, active_nxt;
  logic               first_r, first_nxt;
  lr_pkg::walk_mode_t mode_r, mode_nxt;
  lr_pkg::coord_t     cur_x_r, cur_x_nxt;
  lr_pkg::coord_t     cur_y_r, cur_y_nxt;
  lr_pkg::coord_t     major_end_r, major_end_nxt;
  lr_pkg::dec_t       dec_r, dec_nxt;
  lr_pkg::axial_t     axial_r, axial_nxt;
  lr_pkg::dec_t       diag_r, diag_nxt;
  logic               minor_dir_r, minor_dir_nxt;
  logic               out_valid_r, out_valid_nxt;
  lr_pkg::out_item_t  out_item_r, out_item_nxt;

  lr_pkg::coord_t     step_x;
  lr_pkg::coord_t     step_y;
  lr_pkg::dec_t       step_dec;
  lr_pkg::coord_t     minor_x;
  lr_pkg::coord_t     minor_y;
  lr_pkg::coord_t     nx;
  lr_pkg::coord_t     ny;
  logic               dec_le0;
  logic               last;

  always_comb begin
    dec_le0  = dec_r[lr_pkg::DEC_BITS-1] || (dec_r == '0);
    minor_x  = minor_dir_r ? cur_x_r - lr_pkg::COORD_ONE : cur_x_r + lr_pkg::COORD_ONE;
    minor_y  = minor_dir_r ? cur_y_r - lr_pkg::COORD_ONE : cur_y_r + lr_pkg::COORD_ONE;
    step_x   = cur_x_r;
    step_y   = cur_y_r;
    step_dec = dec_le0 ? dec_r + lr_pkg::dec_t'(axial_r) : dec_r + diag_r;

    unique case (mode_r)
      lr_pkg::MODE_VERT:      step_y = cur_y_r + lr_pkg::COORD_ONE;
      lr_pkg::MODE_HORIZ:     step_x = cur_x_r + lr_pkg::COORD_ONE;
      lr_pkg::MODE_DIAG_UP: begin
        step_x = cur_x_r + lr_pkg::COORD_ONE;
        step_y = minor_y;
      end
      lr_pkg::MODE_DIAG_DOWN: begin
        step_x = cur_x_r - lr_pkg::COORD_ONE;
        step_y = minor_y;
      end
      lr_pkg::MODE_SHALLOW: begin
        step_x = cur_x_r + lr_pkg::COORD_ONE;
        step_y = dec_le0 ? cur_y_r : minor_y;
      end
      lr_pkg::MODE_STEEP: begin
        step_y = cur_y_r + lr_pkg::COORD_ONE;
        step_x = dec_le0 ? cur_x_r : minor_x;
      end
      default: ;
    endcase

    // the first step shows the start pixel without moving
    nx = first_r ? cur_x_r : step_x;
    ny = first_r ? cur_y_r : step_y;

    unique case (mode_r) inside
      lr_pkg::MODE_POINT:                    last = 1'b1;
      lr_pkg::MODE_VERT, lr_pkg::MODE_STEEP: last = (ny == major_end_r);
      default:                               last = (nx == major_end_r);
    endcase

    active_nxt    = active_r;
    first_nxt     = first_r;
    mode_nxt      = mode_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    dec_nxt       = dec_r;
    axial_nxt     = axial_r;
    diag_nxt      = diag_r;
    minor_dir_nxt = minor_dir_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (item_valid && item.command == lr_pkg::CMD_LOAD) begin
      active_nxt    = 1'b1;
      first_nxt     = 1'b1;
      mode_nxt      = setup.mode;
      cur_x_nxt     = setup.cur_x;
      cur_y_nxt     = setup.cur_y;
      major_end_nxt = setup.major_end;
      dec_nxt       = setup.dec;
      axial_nxt     = setup.axial;
      diag_nxt      = setup.diag;
      minor_dir_nxt = setup.minor_dir;
    end else if (item_valid && active_r) begin
      first_nxt     = 1'b0;
      cur_x_nxt     = nx;
      cur_y_nxt     = ny;
      if (!first_r && (mode_r == lr_pkg::MODE_SHALLOW || mode_r == lr_pkg::MODE_STEEP)) begin
        dec_nxt = step_dec;
      end
      active_nxt    = ~last;
      out_valid_nxt = 1'b1;
      out_item_nxt.pixel_x    = nx;
      out_item_nxt.pixel_y    = ny;
      out_item_nxt.last_pixel = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    major_end_r <= major_end_nxt;
    dec_r       <= dec_nxt;
    axial_r     <= axial_nxt;
    diag_r      <= diag_nxt;
    minor_dir_r <= minor_dir_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last_pixel |-> !active_r)
    else $error("line still active after its last pixel");

  a_pixel_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(active_r))
    else $error("pixel given with no line active");

endmodule

// File: verif/tb.sv
// Self-checking testbench for line_rasterizer_core: directed table, then random line walks.
// Depends on lr_pkg for the transaction structs and the command and walk-mode enums.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  // Directed rows either carry a typed pixel, expect nothing, or defer to the predictor.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PIXEL
  } chk_t;

  typedef struct {
    in_item_t  item;
    chk_t      chk;
    out_item_t pix;
  } dir_row_t;

  localparam int RAND_ITEMS = 1000;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  line_rasterizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Walk state of the predictor, held in int variables; pixels are cast to coord_t on output.
  logic       line_on;
  walk_mode_t mode_q;
  int         cur_x, cur_y, end_major;
  int         dec_q, axial_inc, diag_inc;
  logic       minor_neg;
  logic       first_due;

  out_item_t  pixels_due[$];
  int         errors;
  int         items_sent;
  bit         gaps_on;
  dir_row_t   dir_rows[$];
  out_item_t  want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Latch a new line or advance the current one; a pixel comes only on a step with a live line.
  task automatic predict_pixel(input in_item_t it, output bit got, output out_item_t pix);
    int  x1, y1, x2, y2, dx, dy, ax, ay, t, m;
    bit  last;
    got = 1'b0;
    pix = '0;
    if (it.command == CMD_LOAD) begin
      x1 = it.start_x;
      y1 = it.start_y;
      x2 = it.end_x;
      y2 = it.end_y;
      dx = x2 - x1;
      dy = y2 - y1;
      line_on   = 1'b1;
      first_due = 1'b1;
      dec_q     = 0;
      axial_inc = 0;
      diag_inc  = 0;
      minor_neg = 1'b0;
      if (dx == 0 && dy == 0) begin
        mode_q = MODE_POINT;
        cur_x = x1; cur_y = y1; end_major = x1;
      end else if (dx == 0) begin
        // Vertical: walk from the lower y upward.
        mode_q = MODE_VERT;
        cur_x = x1;
        cur_y = (y1 < y2) ? y1 : y2;
        end_major = (y1 < y2) ? y2 : y1;
      end else if (dy == 0) begin
        // Horizontal: walk from the left end.
        mode_q = MODE_HORIZ;
        cur_y = y1;
        cur_x = (x1 < x2) ? x1 : x2;
        end_major = (x1 < x2) ? x2 : x1;
      end else if (iabs(dx) == iabs(dy)) begin
        // 45-degree diagonal: keep the first endpoint as origin.
        mode_q = (dx > 0) ? MODE_DIAG_UP : MODE_DIAG_DOWN;
        minor_neg = (dy < 0);
        cur_x = x1; cur_y = y1; end_major = x2;
      end else if (iabs(dy) < iabs(dx)) begin
        // Shallow: swap so x rises.
        mode_q = MODE_SHALLOW;
        if (dx < 0) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
          dx = -dx; dy = -dy;
        end
        minor_neg = (dy < 0);
        ax = dx;
        ay = iabs(dy);
        dec_q     = 2 * ay - ax;
        axial_inc = 2 * ay;
        diag_inc  = 2 * (ay - ax);
        cur_x = x1; cur_y = y1; end_major = x2;
      end else begin
        // Steep: swap so y rises.
        mode_q = MODE_STEEP;
        if (dy < 0) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
          dx = -dx; dy = -dy;
        end
        minor_neg = (dx < 0);
        ax = iabs(dx);
        ay = dy;
        dec_q     = 2 * ax - ay;
        axial_inc = 2 * ax;
        diag_inc  = 2 * (ax - ay);
        cur_x = x1; cur_y = y1; end_major = y2;
      end
    end else if (line_on) begin
      m = minor_neg ? -1 : 1;
      if (first_due) begin
        first_due = 1'b0;
      end else begin
        case (mode_q)
          MODE_VERT: begin
            cur_y++;
          end
          MODE_HORIZ: begin
            cur_x++;
          end
          MODE_DIAG_UP, MODE_DIAG_DOWN: begin
            cur_x += (mode_q == MODE_DIAG_UP) ? 1 : -1;
            cur_y += m;
          end
          MODE_SHALLOW: begin
            if (dec_q <= 0) begin
              dec_q += axial_inc;
            end else begin
              dec_q += diag_inc;
              cur_y += m;
            end
            cur_x++;
          end
          MODE_STEEP: begin
            if (dec_q <= 0) begin
              dec_q += axial_inc;
            end else begin
              dec_q += diag_inc;
              cur_x += m;
            end
            cur_y++;
          end
          default: begin
          end
        endcase
      end
      if (mode_q == MODE_POINT)
        last = 1'b1;
      else if (mode_q == MODE_VERT || mode_q == MODE_STEEP)
        last = (cur_y == end_major);
      else
        last = (cur_x == end_major);
      if (last)
        line_on = 1'b0;
      pix.pixel_x    = coord_t'(cur_x);
      pix.pixel_y    = coord_t'(cur_y);
      pix.last_pixel = last;
      got = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what, input out_item_t exp, input out_item_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b", $realtime,
               what, exp.pixel_x, exp.pixel_y, exp.last_pixel,
               got.pixel_x, got.pixel_y, got.last_pixel);
  endtask

  // Results cannot be held off: take every strobed pixel and match it against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (pixels_due.size() == 0) begin
        note_mismatch("pixel with none due", '0, out_item);
      end else begin
        want = pixels_due.pop_front();
        if (out_valid !== 1'b1 || out_item.pixel_x !== want.pixel_x ||
            out_item.pixel_y !== want.pixel_y || out_item.last_pixel !== want.last_pixel)
          note_mismatch("pixel mismatch", want, out_item);
      end
    end
  end

  // Present one transaction, with optional random idle cycles ahead of it, and hold it until
  // the block takes it. At the accepting edge, update the predictor and queue what is due.
  task automatic send_item(input in_item_t it, input chk_t chk, input out_item_t typed);
    bit        got;
    out_item_t pix;
    while (gaps_on && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    items_sent++;
    predict_pixel(it, got, pix);
    if (chk == CHK_PIXEL)
      pixels_due.push_back(typed);
    else if (chk == CHK_MODEL && got)
      pixels_due.push_back(pix);
  endtask

  // Hold the sender off until every queued pixel has come back.
  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic dir_row_t row(logic cmd, int sx, int sy, int ex, int ey, chk_t chk,
                                   int px = 0, int py = 0, logic last = 1'b0);
    dir_row_t r;
    r.item.command  = cmd;
    r.item.start_x  = coord_t'(sx);
    r.item.start_y  = coord_t'(sy);
    r.item.end_x    = coord_t'(ex);
    r.item.end_y    = coord_t'(ey);
    r.chk           = chk;
    r.pix.pixel_x    = coord_t'(px);
    r.pix.pixel_y    = coord_t'(py);
    r.pix.last_pixel = last;
    return r;
  endfunction

  function automatic in_item_t step_item();
    in_item_t it;
    it.command = CMD_STEP;
    it.start_x = coord_t'($urandom);
    it.start_y = coord_t'($urandom);
    it.end_x   = coord_t'($urandom);
    it.end_y   = coord_t'($urandom);
    return it;
  endfunction

  // Pick a start so that start + d stays inside the coordinate range.
  task automatic place(input int d, output coord_t s, output coord_t e);
    int lo, hi, v;
    lo = -2048 - ((d < 0) ? d : 0);
    hi = 2047 - ((d > 0) ? d : 0);
    v  = lo + int'($urandom_range(hi - lo));
    s  = coord_t'(v);
    e  = coord_t'(v + d);
  endtask

  // Build a random load; mostly short lines, with forced points, axis lines and diagonals.
  task automatic make_line(output in_item_t it, output int n_pix);
    int pick, dx, dy, sgn;
    pick = $urandom_range(99);
    it.command = CMD_LOAD;
    dx = 0;
    dy = 0;
    if (pick < 8) begin
      dx = 0; dy = 0;
    end else if (pick < 18) begin
      dy = int'($urandom_range(20, 1)) * (($urandom_range(1) != 0) ? -1 : 1);
    end else if (pick < 28) begin
      dx = int'($urandom_range(20, 1)) * (($urandom_range(1) != 0) ? -1 : 1);
    end else if (pick < 40) begin
      sgn = int'($urandom_range(20, 1));
      dx = sgn * (($urandom_range(1) != 0) ? -1 : 1);
      dy = sgn * (($urandom_range(1) != 0) ? -1 : 1);
    end else if (pick < 85) begin
      dx = int'($urandom_range(48)) - 24;
      dy = int'($urandom_range(48)) - 24;
    end else if (pick < 95) begin
      dx = int'($urandom_range(400)) - 200;
      dy = int'($urandom_range(400)) - 200;
    end
    if (pick < 95) begin
      place(dx, it.start_x, it.end_x);
      place(dy, it.start_y, it.end_y);
    end else begin
      // Full-range endpoints reach every coordinate bit.
      it.start_x = coord_t'($urandom);
      it.start_y = coord_t'($urandom);
      it.end_x   = coord_t'($urandom);
      it.end_y   = coord_t'($urandom);
    end
    dx = int'(it.end_x) - int'(it.start_x);
    dy = int'(it.end_y) - int'(it.start_y);
    n_pix = ((iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy)) + 1;
  endtask

  initial begin : stimulus
    in_item_t it;
    int       n_pix, n_steps, r, goal;
    bit       mid_drained;

    errors      = 0;
    items_sent  = 0;
    gaps_on     = 1'b1;
    mid_drained = 1'b0;
    line_on     = 1'b0;
    mode_q      = MODE_POINT;
    cur_x = 0; cur_y = 0; end_major = 0;
    dec_q = 0; axial_inc = 0; diag_inc = 0;
    minor_neg = 1'b0;
    first_due = 1'b0;

    // Directed: step with no line, point, axis lines at the extremes, both diagonals,
    // loads that replace a line in progress, and long shallow and steep lines.
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_NONE));
    dir_rows.push_back(row(CMD_LOAD, 5, -3, 5, -3, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 5, -3, 1'b1));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_NONE));
    dir_rows.push_back(row(CMD_LOAD, -2048, 2047, -2048, 2045, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 2047, 2047, 2047, 2047, CHK_PIXEL, -2048, 2045, 1'b0));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, -2048, 2046, 1'b0));
    dir_rows.push_back(row(CMD_STEP, -1, -1, -1, -1, CHK_PIXEL, -2048, 2047, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 2047, 0, 2045, 0, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 2045, 0, 1'b0));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 2046, 0, 1'b0));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 2047, 0, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 0, 0, 2, -2, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 1'b0));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 1, -1, 1'b0));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 2, -2, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 3, 3, 1, 5, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_PIXEL, 3, 3, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 2047, 5, -2048, -4, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_MODEL));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_MODEL));
    dir_rows.push_back(row(CMD_LOAD, -7, 2047, 2047, -2048, CHK_NONE));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_MODEL));
    dir_rows.push_back(row(CMD_STEP, 0, 0, 0, 0, CHK_MODEL));

    // Hold reset at the start, once, then release it.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].pix);
    drain_pixels();

    // Random: loads followed mostly by a complete walk, sometimes cut short by the next
    // load, sometimes overrun by extra steps that land on no line.
    goal = items_sent + RAND_ITEMS;
    while (items_sent < goal) begin
      // Drop idle gaps for a long stretch in the middle.
      gaps_on = !(items_sent >= 300 && items_sent < 550);
      if (!mid_drained && items_sent >= 700) begin
        drain_pixels();
        mid_drained = 1'b1;
      end
      make_line(it, n_pix);
      send_item(it, CHK_MODEL, '0);
      r = $urandom_range(99);
      if (r < 75)
        n_steps = n_pix + ((r < 55) ? 0 : int'($urandom_range(2, 1)));
      else if (r < 92)
        n_steps = int'($urandom_range(n_pix, 1));
      else
        n_steps = 0;
      // Cap full-range lines so they do not eat the item budget.
      if (n_steps > 64 && n_pix > 401)
        n_steps = int'($urandom_range(64, 5));
      repeat (n_steps)
        send_item(step_item(), CHK_MODEL, '0);
    end

    // Wait for the tail of the pipeline, then flag anything left over.
    start <= 1'b0;
    for (int w = 0; w < 2000 && pixels_due.size() != 0; w++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (pixels_due.size() != 0) begin
      errors += pixels_due.size();
      if (errors <= 10)
        $display("%0d pixels never arrived", pixels_due.size());
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: line_rasterizer_core.f
design/lr_pkg.sv
design/lr_setup.sv
design/lr_walk.sv
design/line_rasterizer_core.sv
verif/tb.sv
